/* rtl/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyframe track sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [2:0] SRC_ACCEPTED = 3'd0;
  localparam logic [2:0] SRC_DROPPED  = 3'd1;
  localparam logic [2:0] SRC_DEFAULT  = 3'd2;
  localparam logic [2:0] SRC_SINGLE   = 3'd3;
  localparam logic [2:0] SRC_LAST     = 3'd4;
  localparam logic [2:0] SRC_FIRST    = 3'd5;
  localparam logic [2:0] SRC_INTERP   = 3'd6;

  localparam logic       CFG_FRAME_COUNT = 1'b0;
  localparam logic       CFG_TRACK_KIND  = 1'b1;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // datapath commands
  typedef struct packed {
    logic        ld_frame;   // capture the sample time of the accepted item
    logic        wr_key;     // write the input key at key_count
    logic        rd_key;     // read entry rd_addr into the data register
    logic        ld_lo;      // copy data register into the lower key register
    logic        ld_out_key; // present data register as the result
    logic        ld_out_def; // present the default value
    logic        ld_out_zero;
    logic        div_start;  // start fraction division from lo and data reg
    logic        mul_start;  // start blend multiplies
    logic        ld_out_mul; // present the blend result
  } kts_cmd_t;

  typedef struct packed {
    logic        div_done;
    logic        mul_done;
    logic        t_lt_data;  // sample time below the data register time
  } kts_sts_t;

endpackage

`default_nettype wire

/* rtl/keyframe_track_sampler_core.sv */
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core
// Keyframe track store with linear interpolation sampler.
// ----------------------------------------------------------------------------
// Clear and append items and a sample of an empty track go straight to the
// result; a single key or the last frame first loads that key. Any other
// sample walks the key memory one entry a cycle, up to the last stored key. An
// interpolated sample then runs a 40-step restoring divider for the fraction
// and a serial multiplier for the three components. One item is in work at a
// time; the result register holds until taken.
`default_nettype none

module keyframe_track_sampler_core #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [23:0] key_time_i,
  input  wire logic [31:0] key_x_i,
  input  wire logic [31:0] key_y_i,
  input  wire logic [31:0] key_z_i,
  input  wire logic [15:0] sample_frame_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      val_x_o,
  output logic [31:0]      val_y_o,
  output logic [31:0]      val_z_o,
  output logic [2:0]       source_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_KEYS);

  logic [16:0] frame_count_q;
  logic        track_kind_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 17'd1;
      track_kind_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == kts_pkg::CFG_FRAME_COUNT) frame_count_q <= cfg_data_i;
      else track_kind_q <= cfg_data_i[0];
    end
  end

  kts_pkg::kts_cmd_t cmd;
  kts_pkg::kts_sts_t sts;
  logic [AW-1:0] wr_addr, rd_addr;

  kts_ctrl #(.AW(AW), .MaxKeys(MAX_KEYS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .sample_frame_i,
    .frame_count_i(frame_count_q), .out_valid_o, .out_stall_i, .source_o,
    .cmd_o(cmd), .sts_i(sts), .wr_addr_o(wr_addr), .rd_addr_o(rd_addr)
  );

  kts_datapath #(.AW(AW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .wr_addr_i(wr_addr),
    .rd_addr_i(rd_addr), .key_time_i, .key_x_i, .key_y_i, .key_z_i,
    .sample_frame_i, .track_kind_i(track_kind_q), .val_x_o, .val_y_o, .val_z_o
  );

endmodule

`default_nettype wire

/* rtl/kts_datapath.sv */
// ----------------------------------------------------------------------------
// kts_datapath
// Key memory, sequential fraction divider and serial blend multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_datapath #(
  parameter int AW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kts_pkg::kts_cmd_t cmd_i,
  output kts_pkg::kts_sts_t      sts_o,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  input  wire logic [23:0]       key_time_i,
  input  wire logic [31:0]       key_x_i,
  input  wire logic [31:0]       key_y_i,
  input  wire logic [31:0]       key_z_i,
  input  wire logic [15:0]       sample_frame_i,
  input  wire logic              track_kind_i,
  output logic [31:0]            val_x_o,
  output logic [31:0]            val_y_o,
  output logic [31:0]            val_z_o
);

  localparam int Depth = 1 << AW;

  logic [119:0] mem_q [Depth];
  logic [119:0] rd_q, lo_q;
  logic [31:0]  ox_q, oy_q, oz_q;
  logic [23:0]  t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key) begin
      mem_q[wr_addr_i] <= {key_time_i, key_x_i, key_y_i, key_z_i};
    end
    if (cmd_i.rd_key) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (cmd_i.ld_lo) begin
      lo_q <= rd_q;
    end
    if (cmd_i.ld_frame) begin
      t_q <= {sample_frame_i, 8'd0};
    end
  end

  // restoring divider: (t - lo) << 16 / (hi - lo), 40-bit quotient
  logic [39:0] quo_q;
  logic [24:0] rem_q;
  logic [23:0] den_q;
  logic [5:0]  dcnt_q;
  logic        dbusy_q;
  logic [24:0] rem_sh;
  logic [25:0] rem_sub;
  assign rem_sh  = {rem_q[23:0], quo_q[39]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, den_q};

  // serial multiply: diff (33b signed) times f (17b unsigned), one component
  // a pass, by shift-add
  logic [1:0]  comp_q;
  logic [4:0]  mcnt_q;
  logic        mbusy_q;
  logic        mdone_q;
  logic [16:0] f_q;
  logic signed [49:0] acc_q;
  logic signed [32:0] diff_w;
  logic signed [31:0] s_w, e_w;
  logic signed [49:0] q_w;
  logic [31:0] res_w;

  always_comb begin
    case (comp_q)
      2'd0:    begin s_w = lo_q[95:64]; e_w = rd_q[95:64]; end
      2'd1:    begin s_w = lo_q[63:32]; e_w = rd_q[63:32]; end
      default: begin s_w = lo_q[31:0];  e_w = rd_q[31:0];  end
    endcase
    diff_w = 33'(e_w) - 33'(s_w);
    if (acc_q < 0) begin
      q_w = -((-acc_q) >>> 16);
    end else begin
      q_w = acc_q >>> 16;
    end
    res_w = 32'(s_w) + q_w[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      comp_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= mbusy_q && mcnt_q == 5'd0 && comp_q == 2'd2;
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 6'd40;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) begin
          dbusy_q <= 1'b0;
        end
      end
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
        comp_q  <= '0;
        mcnt_q  <= 5'd17;
      end else if (mbusy_q) begin
        if (mcnt_q == 5'd0) begin
          if (comp_q == 2'd2) begin
            mbusy_q <= 1'b0;
          end else begin
            comp_q <= comp_q + 2'd1;
            mcnt_q <= 5'd17;
          end
        end else begin
          mcnt_q <= mcnt_q - 5'd1;
        end
      end
    end
  end

  assign sts_o = '{div_done:  !dbusy_q && !cmd_i.div_start,
                   mul_done:  mdone_q,
                   t_lt_data: t_q < rd_q[119:96]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= {t_q - lo_q[119:96], 16'd0};
      rem_q <= '0;
      den_q <= rd_q[119:96] - lo_q[119:96];
    end else if (dbusy_q) begin
      if (!rem_sub[25]) begin
        rem_q <= rem_sub[24:0];
        quo_q <= {quo_q[38:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[38:0], 1'b0};
      end
    end
    if (cmd_i.mul_start || (mbusy_q && mcnt_q == 5'd0)) begin
      f_q   <= quo_q[16:0];
      acc_q <= '0;
    end else if (mbusy_q) begin
      // MSB-first shift-add
      acc_q <= (acc_q <<< 1) + (f_q[16] ? 50'(diff_w) : 50'sd0);
      f_q   <= {f_q[15:0], 1'b0};
    end
    if (mbusy_q && mcnt_q == 5'd0) begin
      case (comp_q)
        2'd0:    ox_q <= res_w;
        2'd1:    oy_q <= res_w;
        default: oz_q <= res_w;
      endcase
    end
    if (cmd_i.ld_out_key) begin
      ox_q <= rd_q[95:64]; oy_q <= rd_q[63:32]; oz_q <= rd_q[31:0];
    end
    if (cmd_i.ld_out_def) begin
      ox_q <= track_kind_i ? kts_pkg::ONE_Q16 : '0;
      oy_q <= track_kind_i ? kts_pkg::ONE_Q16 : '0;
      oz_q <= track_kind_i ? kts_pkg::ONE_Q16 : '0;
    end
    if (cmd_i.ld_out_zero) begin
      ox_q <= '0; oy_q <= '0; oz_q <= '0;
    end
  end

  assign val_x_o = ox_q;
  assign val_y_o = oy_q;
  assign val_z_o = oz_q;

endmodule

`default_nettype wire

/* rtl/kts_ctrl.sv */
// ----------------------------------------------------------------------------
// kts_ctrl
// Controller: accepts items, walks the key table, sequences divide and blend.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_ctrl #(
  parameter int AW = 6,
  parameter int MaxKeys = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [15:0]       sample_frame_i,
  input  wire logic [16:0]       frame_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             source_o,
  output kts_pkg::kts_cmd_t      cmd_o,
  input  wire kts_pkg::kts_sts_t sts_i,
  output logic [AW-1:0]          wr_addr_o,
  output logic [AW-1:0]          rd_addr_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1; // data reg holds entry idx
  localparam logic [2:0] ST_CHK   = 3'd2; // read lower entry idx
  localparam logic [2:0] ST_FIN   = 3'd3; // lower entry in data reg
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_KEY   = 3'd6; // output data reg when read lands
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]  st_q;
  logic [AW:0] cnt_q;
  logic [AW:0] idx_q;   // entry being checked
  logic [2:0]  src_q;
  logic        div_run_q;
  logic [AW:0] last_w;
  logic        acc_w;
  logic        last_frame_w;

  assign in_stall_o   = (st_q != ST_IDLE);
  assign out_valid_o  = (st_q == ST_OUT);
  assign source_o     = src_q;
  assign acc_w        = in_valid_i && !in_stall_o;
  assign last_w       = cnt_q - (AW+1)'(1);
  assign wr_addr_o    = cnt_q[AW-1:0];
  assign last_frame_w = frame_count_i != '0 &&
                        {1'b0, sample_frame_i} == frame_count_i - 17'd1;

  always_comb begin
    cmd_o = '0;
    rd_addr_o = idx_q[AW-1:0];
    case (st_q)
      ST_IDLE: begin
        if (acc_w) begin
          cmd_o.ld_frame = 1'b1;
          case (mode_i)
            kts_pkg::MODE_APPEND: begin
              cmd_o.wr_key      = (cnt_q < (AW+1)'(MaxKeys));
              cmd_o.ld_out_zero = 1'b1;
            end
            kts_pkg::MODE_SAMPLE: begin
              if (cnt_q == '0) begin
                cmd_o.ld_out_def = 1'b1;
              end else begin
                // single key or last frame read entry 0 / last; else entry 1
                cmd_o.rd_key = 1'b1;
                if (cnt_q == (AW+1)'(1)) rd_addr_o = '0;
                else if (last_frame_w) rd_addr_o = last_w[AW-1:0];
                else rd_addr_o = (AW)'(1);
              end
            end
            default: cmd_o.ld_out_zero = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        // advance to the next upper candidate
        if (!sts_i.t_lt_data && idx_q != last_w) begin
          cmd_o.rd_key = 1'b1;
          rd_addr_o    = idx_q[AW-1:0] + (AW)'(1);
        end
      end
      ST_CHK: begin
        cmd_o.rd_key = 1'b1;
      end
      ST_FIN: begin
        cmd_o.ld_lo = 1'b1;
        if (sts_i.t_lt_data) begin
          cmd_o.ld_out_key = 1'b1;
        end else begin
          // fetch the upper key again while lo is loaded
          cmd_o.rd_key = 1'b1;
          rd_addr_o    = idx_q[AW-1:0] + (AW)'(1);
        end
      end
      ST_DIV: begin
        if (!div_run_q) cmd_o.div_start = 1'b1;
        else if (sts_i.div_done) cmd_o.mul_start = 1'b1;
      end
      ST_KEY: cmd_o.ld_out_key = 1'b1;
      default: ;
    endcase
  end

  // div_run_q is the sub-phase flag of the DIV state: 0 issue start, 1 wait
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      src_q     <= kts_pkg::SRC_ACCEPTED;
      div_run_q <= 1'b0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (acc_w) begin
            case (mode_i)
              kts_pkg::MODE_CLEAR: begin
                cnt_q <= '0;
                src_q <= kts_pkg::SRC_ACCEPTED;
                st_q  <= ST_OUT;
              end
              kts_pkg::MODE_APPEND: begin
                if (cnt_q < (AW+1)'(MaxKeys)) begin
                  cnt_q <= cnt_q + (AW+1)'(1);
                  src_q <= kts_pkg::SRC_ACCEPTED;
                end else begin
                  src_q <= kts_pkg::SRC_DROPPED;
                end
                st_q <= ST_OUT;
              end
              kts_pkg::MODE_SAMPLE: begin
                if (cnt_q == '0) begin
                  src_q <= kts_pkg::SRC_DEFAULT; st_q <= ST_OUT;
                end else if (cnt_q == (AW+1)'(1)) begin
                  src_q <= kts_pkg::SRC_SINGLE; st_q <= ST_KEY;
                end else if (last_frame_w) begin
                  src_q <= kts_pkg::SRC_LAST; st_q <= ST_KEY;
                end else begin
                  idx_q <= (AW+1)'(1);
                  st_q  <= ST_RD;
                end
              end
              default: begin
                src_q <= kts_pkg::SRC_ACCEPTED;
                st_q  <= ST_OUT;
              end
            endcase
          end
        end
        ST_RD: begin
          // data reg holds entry idx; bracket found if t < time[idx]
          if (sts_i.t_lt_data) begin
            idx_q <= idx_q - (AW+1)'(1);
            st_q  <= ST_CHK;
          end else if (idx_q == last_w) begin
            src_q <= kts_pkg::SRC_LAST; st_q <= ST_KEY;
          end else begin
            idx_q <= idx_q + (AW+1)'(1);
          end
        end
        ST_CHK: begin
          st_q <= ST_FIN;
        end
        ST_FIN: begin
          // below the lower key only happens for entry 0
          if (sts_i.t_lt_data) begin
            src_q <= kts_pkg::SRC_FIRST;
            st_q  <= ST_OUT;
          end else begin
            src_q <= kts_pkg::SRC_INTERP;
            st_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (sts_i.div_done) begin
            div_run_q <= 1'b0;
            st_q      <= ST_MUL;
          end
        end
        ST_MUL: if (sts_i.mul_done) st_q <= ST_OUT;
        ST_KEY: st_q <= ST_OUT;
        ST_OUT: if (!out_stall_i) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe track sampler: directed and random
// clear, append and sample items are checked against a local track predictor.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_KEYS = 64;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  src;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [23:0] key_time_i = '0;
  logic [31:0] key_x_i = '0;
  logic [31:0] key_y_i = '0;
  logic [31:0] key_z_i = '0;
  logic [15:0] sample_frame_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] val_x_o;
  logic [31:0] val_y_o;
  logic [31:0] val_z_o;
  logic [2:0]  source_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  keyframe_track_sampler_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [16:0] frame_cnt = 17'd1;
  logic        scale_track = 1'b0;
  int          n_keys = 0;
  logic [23:0] trk_time [NUM_KEYS];
  logic [31:0] trk_x [NUM_KEYS];
  logic [31:0] trk_y [NUM_KEYS];
  logic [31:0] trk_z [NUM_KEYS];

  sample_t     pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  int          burst_gap = 0;

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, longint f);
    longint s, p, q;
    s = longint'($signed(a));
    p = (longint'($signed(b)) - s) * f;
    q = (p >= 0) ? p / 65536 : -((-p) / 65536);
    return 32'(s + q);
  endfunction

  function automatic sample_t key_at(int k, logic [2:0] src);
    return '{trk_x[k], trk_y[k], trk_z[k], src};
  endfunction

  function automatic sample_t predict_track(logic [1:0] mode, logic [23:0] kt,
      logic [31:0] kx, logic [31:0] ky, logic [31:0] kz, logic [15:0] fr);
    sample_t r;
    logic [31:0] t;
    int hit;
    longint f;
    r = '{32'd0, 32'd0, 32'd0, kts_pkg::SRC_ACCEPTED};
    t = {8'd0, fr, 8'd0};
    hit = -1;
    if (mode == kts_pkg::MODE_CLEAR) begin
      n_keys = 0;
    end else if (mode == kts_pkg::MODE_APPEND) begin
      if (n_keys < NUM_KEYS) begin
        trk_time[n_keys] = kt; trk_x[n_keys] = kx;
        trk_y[n_keys] = ky; trk_z[n_keys] = kz;
        n_keys++;
      end else begin
        r.src = kts_pkg::SRC_DROPPED;
      end
    end else if (mode == kts_pkg::MODE_SAMPLE) begin
      if (n_keys == 0) begin
        r.x = scale_track ? kts_pkg::ONE_Q16 : 32'd0;
        r.y = r.x; r.z = r.x; r.src = kts_pkg::SRC_DEFAULT;
      end else if (n_keys == 1) begin
        r = key_at(0, kts_pkg::SRC_SINGLE);
      end else if (frame_cnt != 0 && {1'b0, fr} == frame_cnt - 17'd1) begin
        r = key_at(n_keys - 1, kts_pkg::SRC_LAST);
      end else begin
        for (int i = 0; i + 1 < n_keys; i++)
          if (hit < 0 && t < trk_time[i + 1]) hit = i;
        if (hit < 0) r = key_at(n_keys - 1, kts_pkg::SRC_LAST);
        else if (t < trk_time[hit]) r = key_at(0, kts_pkg::SRC_FIRST);
        else begin
          f = (longint'(t - trk_time[hit]) << 16) /
              longint'(trk_time[hit + 1] - trk_time[hit]);
          r.x = lerp(trk_x[hit], trk_x[hit + 1], f);
          r.y = lerp(trk_y[hit], trk_y[hit + 1], f);
          r.z = lerp(trk_z[hit], trk_z[hit + 1], f);
          r.src = kts_pkg::SRC_INTERP;
        end
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    sample_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result source=%0d", source_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (val_x_o !== e.x) begin $error("val_x exp %h got %h", e.x, val_x_o); errors++; end
        if (val_y_o !== e.y) begin $error("val_y exp %h got %h", e.y, val_y_o); errors++; end
        if (val_z_o !== e.z) begin $error("val_z exp %h got %h", e.z, val_z_o); errors++; end
        if (source_o !== e.src) begin
          $error("source exp %0d got %0d", e.src, source_o); errors++;
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else if (cycles % 3000 < 1000) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back items; drop it only for a gap
  task automatic send_item(logic [1:0] mode, logic [23:0] kt, logic [31:0] kx,
      logic [31:0] ky, logic [31:0] kz, logic [15:0] fr);
    int gap;
    if (burst_gap == 0) begin
      burst_gap = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_gap--;
    in_valid_i <= 1'b1;
    mode_i <= mode; key_time_i <= kt; key_x_i <= kx;
    key_y_i <= ky; key_z_i <= kz; sample_frame_i <= fr;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.insert(pending_q.size(), predict_track(mode, kt, kx, ky, kz, fr));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == kts_pkg::CFG_FRAME_COUNT) frame_cnt = val;
    else scale_track = val[0];
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic append_key(logic [23:0] kt);
    send_item(kts_pkg::MODE_APPEND, kt, rand_val(), rand_val(), rand_val(), 16'($urandom));
  endtask

  task automatic sample_at(logic [15:0] fr);
    send_item(kts_pkg::MODE_SAMPLE, 24'($urandom), $urandom, $urandom, $urandom, fr);
  endtask

  task automatic test_directed();
    sample_at(16'd5);                       // empty position track
    write_reg(kts_pkg::CFG_TRACK_KIND, 17'd1);
    sample_at(16'hFFFF);                    // empty scale track
    append_key(24'h000100);
    sample_at(16'd0);                       // single key
    append_key(24'h000A00);
    send_item(kts_pkg::MODE_APPEND, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
              16'd0);
    sample_at(16'd0);                       // first frame is the last one
    write_reg(kts_pkg::CFG_FRAME_COUNT, 17'd0);
    sample_at(16'd0);                       // before first key
    sample_at(16'd3);                       // interpolated
    sample_at(16'd200);
    sample_at(16'hFFFF);
    send_item(MODE_UNUSED, 24'hFFFFFF, '1, '1, '1, 16'hFFFF);
    write_reg(kts_pkg::CFG_FRAME_COUNT, 17'h10000);
    sample_at(16'hFFFF);                    // last frame
    send_item(kts_pkg::MODE_CLEAR, '0, '0, '0, '0, '0);
    for (int i = 0; i < NUM_KEYS + 2; i++) append_key(24'(i * 512)); // fills, drops
    sample_at(16'd63);
    sample_at(16'd1000);
  endtask

  task automatic test_pressure();
    drain();
    long_hold = 1'b1;
    fork
      begin repeat (600) @(posedge clk_i); long_hold = 1'b0; end
      begin
        for (int i = 0; i < 12; i++) sample_at(16'($urandom_range(0, 200)));
        drain();
      end
    join
  endtask

  task automatic test_random(int n_items);
    int sent;
    int nk;
    int t;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(kts_pkg::CFG_FRAME_COUNT,
                  ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 2)) :
                  17'($urandom_range(1, 600)));
        write_reg(kts_pkg::CFG_TRACK_KIND, 17'($urandom_range(0, 1)));
      end
      send_item(kts_pkg::MODE_CLEAR, 24'($urandom), $urandom, $urandom, $urandom,
                16'($urandom));
      nk = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
      t = $urandom_range(0, 2000);
      for (int i = 0; i < nk; i++) begin
        // mostly ascending, now and then an out-of-order key
        if ($urandom_range(0, 15) == 0) append_key(24'($urandom));
        else begin
          append_key(24'(t));
          t = t + $urandom_range(1, 4000);
          if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        end
      end
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(0, 7) == 0) sample_at(16'($urandom));
        else if ($urandom_range(0, 7) == 0) sample_at(16'(frame_cnt - 17'd1));
        else sample_at(16'($urandom_range(0, (t >> 8) + 2)));
      end
      sent += nk + 7;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pressure();
    test_random(2000);
    write_reg(kts_pkg::CFG_FRAME_COUNT, 17'd1);
    write_reg(kts_pkg::CFG_TRACK_KIND, 17'd0);
    sample_at(16'd0);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* keyframe_track_sampler_core.f */
rtl/kts_pkg.sv
rtl/kts_datapath.sv
rtl/kts_ctrl.sv
rtl/keyframe_track_sampler_core.sv
verif/tb_top.sv
